### rtl/io_command_and_debounce_controller_top_defines.svh
// Assertion macros for the checker file of the I/O command controller.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef IO_COMMAND_AND_DEBOUNCE_CONTROLLER_TOP_DEFINES_SVH
`define IO_COMMAND_AND_DEBOUNCE_CONTROLLER_TOP_DEFINES_SVH

// Checked only while out of reset.
`define IOCDC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define IOCDC_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/iocdc_pkg.sv
// Shared types, constants and helper functions of the I/O command controller.
// No dependencies.
package iocdc_pkg;

  localparam int unsigned IOCDC_INPUT_COUNT  = 21;
  localparam int unsigned IOCDC_OUTPUT_COUNT = 17;
  localparam int unsigned IOCDC_LINE_DEPTH   = 32;

  localparam int unsigned CFG_W     = 16;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CHAN_W    = 8;
  localparam int unsigned VAL_W     = 12;
  localparam int unsigned TIME_W    = 32;

  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEARTBEAT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REPORT    = 2'd2;

  localparam logic [CFG_W-1:0] DEBOUNCE_RST  = 16'd25;
  localparam logic [CFG_W-1:0] HEARTBEAT_RST = 16'd5000;
  localparam logic [CFG_W-1:0] REPORT_RST    = 16'd100;

  localparam logic [VAL_W-1:0] DAC_MAX = 12'd4095;

  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_D0    = 8'h30;
  localparam logic [7:0] CH_D9    = 8'h39;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;

  // command strings, first character in the top used byte
  localparam logic [63:0] STR_PING = 64'("PING");
  localparam logic [63:0] STR_DI   = 64'("DI_STATE");
  localparam logic [63:0] STR_DOS  = 64'("DO_STATE");
  localparam logic [63:0] STR_DO   = 64'("DO,");
  localparam logic [63:0] STR_AO   = 64'("AO,");
  localparam logic [63:0] STR_PB5  = 64'("PB5,");
  localparam logic [3:0]  LEN_PING = 4'd4;
  localparam logic [3:0]  LEN_STATE = 4'd8;
  localparam logic [3:0]  LEN_PFX  = 4'd3;
  localparam logic [3:0]  LEN_PB5  = 4'd4;

  typedef enum logic [2:0] {
    KIND_PONG, KIND_DI, KIND_DO, KIND_DO_ACK,
    KIND_AO_ACK, KIND_PB5_ACK, KIND_HEARTBEAT, KIND_AI
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    logic [CHAN_W-1:0] channel;
    logic [VAL_W-1:0]  value;
  } res_t;

  typedef enum logic [1:0] {NP_WAIT, NP_WS, NP_DIG, NP_DONE} nparse_t;

  typedef struct packed {
    nparse_t           st;
    logic              neg;
    logic [TIME_W-1:0] acc;
  } num_t;

  typedef enum logic [3:0] {
    OP_IDLE, OP_LATCH, OP_BYTE, OP_SCAN_RD, OP_SCAN_EX, OP_EXEC, OP_REP_DI,
    OP_REP_DO, OP_TICK, OP_DEB, OP_HB, OP_AI_ONE, OP_AI_TWO, OP_FLUSH
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DISPATCH, ST_SCAN_RD, ST_SCAN_EX, ST_EXEC, ST_REP_DI, ST_REP_DO,
    ST_DEB, ST_HB, ST_AI_ONE, ST_AI_TWO, ST_FLUSH
  } state_t;

  typedef struct packed {
    op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic mode_tick;
    logic nl_run;
    logic scan_end;
    logic rep_di;
    logic rep_do;
    logic last_in;
    logic last_out;
    logic out_free;
  } dp_stat_t;

  function automatic logic is_space(input logic [7:0] b);
    return (b == CH_SPACE) || (b >= CH_TAB && b <= CH_CR);
  endfunction

  // character p of a string of length n
  function automatic logic [7:0] str_at(input logic [63:0] s, input logic [2:0] p,
                                        input logic [3:0] n);
    logic [5:0] base;
    base = 6'(({2'b00, n} - 6'd1 - {3'b000, p}) * 6'd8);
    return s[base +: 8];
  endfunction

  // one character of an atoi style number scan
  function automatic num_t num_step(input num_t cur, input logic start,
                                    input logic [7:0] b);
    num_t              nx;
    nparse_t           st;
    logic              dig;
    logic [TIME_W-1:0] d;
    nx  = cur;
    st  = (cur.st == NP_WAIT && start) ? NP_WS : cur.st;
    nx.st = st;
    dig = (b >= CH_D0) && (b <= CH_D9);
    d   = {24'b0, 8'(b - CH_D0)};
    case (st)
      NP_WS: begin
        if (is_space(b)) nx.st = NP_WS;
        else if (b == CH_PLUS || b == CH_MINUS) begin
          nx.neg = (b == CH_MINUS);
          nx.st  = NP_DIG;
        end else if (dig) begin
          nx.acc = d;
          nx.st  = NP_DIG;
        end else nx.st = NP_DONE;
      end
      NP_DIG: begin
        if (dig) nx.acc = (cur.acc << 3) + (cur.acc << 1) + d;
        else nx.st = NP_DONE;
      end
      default: ;
    endcase
    return nx;
  endfunction

  function automatic logic [TIME_W-1:0] num_val(input num_t n);
    return n.neg ? (TIME_W'(0) - n.acc) : n.acc;
  endfunction

endpackage

### rtl/iocdc_in_if.sv
// Input word channel of the I/O command controller.
// Depends on iocdc_pkg.
interface iocdc_in_if import iocdc_pkg::*; #(
  parameter int unsigned INPUT_COUNT = IOCDC_INPUT_COUNT
) ();
  logic                   valid;
  logic                   ready;
  logic                   mode;
  logic [7:0]             rx_char;
  logic [INPUT_COUNT-1:0] di_sample;
  logic [VAL_W-1:0]       analog_one;
  logic [VAL_W-1:0]       analog_two;

  modport source (output valid, mode, rx_char, di_sample, analog_one, analog_two,
                  input ready);
  modport sink (input valid, mode, rx_char, di_sample, analog_one, analog_two,
                output ready);
endinterface

### rtl/iocdc_out_if.sv
// Result word channel of the I/O command controller.
// Depends on iocdc_pkg.
interface iocdc_out_if import iocdc_pkg::*; #(
  parameter int unsigned OUTPUT_COUNT = IOCDC_OUTPUT_COUNT
) ();
  logic                    valid;
  logic                    ready;
  logic [2:0]              kind;
  logic [CHAN_W-1:0]       channel;
  logic [VAL_W-1:0]        value;
  logic                    last;
  logic [OUTPUT_COUNT-1:0] do_levels;
  logic [VAL_W-1:0]        dac_one;
  logic [VAL_W-1:0]        dac_two;
  logic                    pb5_level;

  modport source (output valid, kind, channel, value, last, do_levels, dac_one,
                  dac_two, pb5_level, input ready);
  modport sink (input valid, kind, channel, value, last, do_levels, dac_one,
                dac_two, pb5_level, output ready);
endinterface

### rtl/iocdc_ctrl.sv
// Sequencer of the I/O command controller: steps the datapath through one word.
// Depends on iocdc_pkg.
module iocdc_ctrl import iocdc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cmd.op    = OP_IDLE;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op    = OP_LATCH;
          state_nxt = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        if (stat.mode_tick) begin
          cmd.op    = OP_TICK;
          state_nxt = ST_DEB;
        end else begin
          cmd.op    = OP_BYTE;
          state_nxt = stat.nl_run ? ST_SCAN_RD : ST_IDLE;
        end
      end
      ST_SCAN_RD: begin
        cmd.op    = OP_SCAN_RD;
        state_nxt = ST_SCAN_EX;
      end
      ST_SCAN_EX: begin
        cmd.op    = OP_SCAN_EX;
        state_nxt = stat.scan_end ? ST_EXEC : ST_SCAN_RD;
      end
      ST_EXEC: if (stat.out_free) begin
        cmd.op = OP_EXEC;
        if (stat.rep_di) state_nxt = ST_REP_DI;
        else if (stat.rep_do) state_nxt = ST_REP_DO;
        else state_nxt = ST_FLUSH;
      end
      ST_REP_DI: if (stat.out_free) begin
        cmd.op = OP_REP_DI;
        if (stat.last_in) state_nxt = ST_FLUSH;
      end
      ST_REP_DO: if (stat.out_free) begin
        cmd.op = OP_REP_DO;
        if (stat.last_out) state_nxt = ST_FLUSH;
      end
      ST_DEB: if (stat.out_free) begin
        cmd.op = OP_DEB;
        if (stat.last_in) state_nxt = ST_HB;
      end
      ST_HB: if (stat.out_free) begin
        cmd.op    = OP_HB;
        state_nxt = ST_AI_ONE;
      end
      ST_AI_ONE: if (stat.out_free) begin
        cmd.op    = OP_AI_ONE;
        state_nxt = ST_AI_TWO;
      end
      ST_AI_TWO: if (stat.out_free) begin
        cmd.op    = OP_AI_TWO;
        state_nxt = ST_FLUSH;
      end
      ST_FLUSH: if (stat.out_free) begin
        cmd.op    = OP_FLUSH;
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

### rtl/iocdc_dp.sv
// Datapath of the I/O command controller: line memory, parser, debounce, timers,
// result hold and output registers. Depends on iocdc_pkg.
module iocdc_dp import iocdc_pkg::*; #(
  parameter int unsigned INPUT_COUNT  = IOCDC_INPUT_COUNT,
  parameter int unsigned OUTPUT_COUNT = IOCDC_OUTPUT_COUNT,
  parameter int unsigned LINE_DEPTH   = IOCDC_LINE_DEPTH
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  dp_cmd_t                 cmd,
  output dp_stat_t                stat,
  input  logic                    in_mode,
  input  logic [7:0]              in_rx_char,
  input  logic [INPUT_COUNT-1:0]  in_di_sample,
  input  logic [VAL_W-1:0]        in_analog_one,
  input  logic [VAL_W-1:0]        in_analog_two,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_W-1:0]    cfg_idx,
  input  logic [CFG_W-1:0]        cfg_wdata,
  input  logic                    out_ready,
  output logic                    out_valid,
  output res_t                    out_res,
  output logic                    out_last,
  output logic [OUTPUT_COUNT-1:0] out_do_levels,
  output logic [VAL_W-1:0]        out_dac_one,
  output logic [VAL_W-1:0]        out_dac_two,
  output logic                    out_pb5
);

  localparam int unsigned MAXN = (INPUT_COUNT > OUTPUT_COUNT) ?
    ((INPUT_COUNT > LINE_DEPTH) ? INPUT_COUNT : LINE_DEPTH) :
    ((OUTPUT_COUNT > LINE_DEPTH) ? OUTPUT_COUNT : LINE_DEPTH);
  localparam int unsigned CW  = $clog2(MAXN);
  localparam int unsigned CXW = CW + 1;
  localparam int unsigned AW  = $clog2(LINE_DEPTH);
  localparam int unsigned LW  = $clog2(LINE_DEPTH + 1);
  localparam int unsigned IW  = (INPUT_COUNT > 1) ? $clog2(INPUT_COUNT) : 1;
  localparam int unsigned SW  = (CXW > LW) ? CXW : LW;

  // configuration
  logic [CFG_W-1:0] deb_r, hb_per_r, rep_per_r;

  // latched word
  logic                   mode_r;
  logic [7:0]             rx_r;
  logic [INPUT_COUNT-1:0] din_r;
  logic [VAL_W-1:0]       an1_r, an2_r;

  // line memory and scan state
  logic [7:0]    mem [LINE_DEPTH];
  logic [7:0]    rdata_r;
  logic [LW-1:0] line_len_r, scan_len_r;
  logic [CW-1:0] cnt_r;
  logic          m_ping_r, m_di_r, m_dos_r, m_do_r, m_ao_r, m_pb5_r, comma_r;
  num_t          num1_r, num2_r;

  // board state
  logic [OUTPUT_COUNT-1:0] do_bits_r;
  logic [VAL_W-1:0]        dac1_r, dac2_r;
  logic                    pb5_r;
  logic [INPUT_COUNT-1:0]  raw_r, stable_r;
  logic [TIME_W-1:0]       stamp_r [INPUT_COUNT];
  logic [TIME_W-1:0]       now_r, hb_stamp_r, rep_stamp_r;
  logic                    ai_pend_r;

  // result hold and output
  res_t hold_r;
  logic hold_v_r;
  logic out_valid_r;

  logic [CXW-1:0]    cnt_x, cnt_inc;
  logic [IW-1:0]     ci;
  logic [7:0]        b;
  logic              start1, comma_hit;
  logic [TIME_W-1:0] n1, n2, deb_age;
  logic [7:0]        idx8;
  logic              do_ok, rd, differ, deb_fire, hb_fire, ai_fire;
  logic              is_pong, is_di, is_dos, is_do, is_ao, is_pb5;
  logic [VAL_W-1:0]  ao_val;
  logic              gen_v, load_out;
  res_t              gen;

  assign cnt_x   = {1'b0, cnt_r};
  assign cnt_inc = cnt_x + CXW'(1);
  assign ci      = cnt_r[IW-1:0];
  assign b       = rdata_r;

  assign start1    = (cnt_x == CXW'(3) && !m_pb5_r) || cnt_x == CXW'(4);
  assign comma_hit = (cnt_x >= CXW'(3)) && (b == CH_COMMA) && !comma_r;

  assign n1   = num_val(num1_r);
  assign n2   = num_val(num2_r);
  assign idx8 = n1[7:0];

  assign is_pong = (scan_len_r == LW'(4)) && m_ping_r;
  assign is_di   = (scan_len_r == LW'(8)) && m_di_r;
  assign is_dos  = (scan_len_r == LW'(8)) && m_dos_r;
  assign is_do   = (scan_len_r >= LW'(3)) && m_do_r && comma_r;
  assign is_ao   = (scan_len_r >= LW'(3)) && m_ao_r && comma_r;
  assign is_pb5  = (scan_len_r >= LW'(4)) && m_pb5_r;
  assign do_ok   = (idx8 >= 8'd1) && (idx8 <= 8'(OUTPUT_COUNT));
  assign ao_val  = (n2 > TIME_W'(DAC_MAX)) ? DAC_MAX : n2[VAL_W-1:0];

  // debounce and timers
  assign rd       = din_r[ci];
  assign differ   = rd != raw_r[ci];
  assign deb_age  = now_r - stamp_r[ci];
  assign deb_fire = !differ && (deb_age > TIME_W'(deb_r)) && (rd != stable_r[ci]);
  assign hb_fire  = (now_r - hb_stamp_r) >= TIME_W'(hb_per_r);
  assign ai_fire  = (now_r - rep_stamp_r) >= TIME_W'(rep_per_r);

  // status
  assign stat.mode_tick = mode_r;
  assign stat.nl_run    = (rx_r == CH_NL) && (line_len_r != '0);
  assign stat.scan_end  = (b == 8'd0) || (SW'(cnt_inc) == SW'(line_len_r));
  assign stat.rep_di    = is_di;
  assign stat.rep_do    = is_dos && !is_di;
  assign stat.last_in   = cnt_x == CXW'(INPUT_COUNT - 1);
  assign stat.last_out  = cnt_x == CXW'(OUTPUT_COUNT - 1);
  assign stat.out_free  = !out_valid_r || out_ready;

  // result candidate of this step
  always_comb begin
    gen_v = 1'b0;
    gen   = '{kind: KIND_PONG, channel: '0, value: '0};
    case (cmd.op)
      OP_EXEC: begin
        if (is_pong) gen_v = 1'b1;
        else if (is_di || is_dos) gen_v = 1'b0;
        else if (is_do) begin
          gen_v = do_ok;
          gen   = '{kind: KIND_DO_ACK, channel: idx8,
                    value: VAL_W'(n2[7:0] != 8'd0)};
        end else if (is_ao) begin
          gen_v = 1'b1;
          gen   = '{kind: KIND_AO_ACK, channel: idx8, value: ao_val};
        end else if (is_pb5) begin
          gen_v = 1'b1;
          gen   = '{kind: KIND_PB5_ACK, channel: '0, value: VAL_W'(idx8)};
        end
      end
      OP_REP_DI: begin
        gen_v = 1'b1;
        gen   = '{kind: KIND_DI, channel: 8'(cnt_inc), value: VAL_W'(stable_r[ci])};
      end
      OP_REP_DO: begin
        gen_v = 1'b1;
        gen   = '{kind: KIND_DO, channel: 8'(cnt_inc),
                  value: VAL_W'(do_bits_r[cnt_r[((OUTPUT_COUNT > 1) ?
                                 $clog2(OUTPUT_COUNT) : 1)-1:0]])};
      end
      OP_DEB: begin
        gen_v = deb_fire;
        gen   = '{kind: KIND_DI, channel: 8'(cnt_inc), value: VAL_W'(rd)};
      end
      OP_HB: begin
        gen_v = hb_fire;
        gen   = '{kind: KIND_HEARTBEAT, channel: '0, value: '0};
      end
      OP_AI_ONE: begin
        gen_v = ai_fire;
        gen   = '{kind: KIND_AI, channel: 8'd1, value: an1_r};
      end
      OP_AI_TWO: begin
        gen_v = ai_pend_r;
        gen   = '{kind: KIND_AI, channel: 8'd2, value: an2_r};
      end
      default: ;
    endcase
  end

  // a held result leaves when a newer one arrives or the word is finished
  assign load_out = hold_v_r && (gen_v || cmd.op == OP_FLUSH);

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deb_r     <= DEBOUNCE_RST;
      hb_per_r  <= HEARTBEAT_RST;
      rep_per_r <= REPORT_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_DEBOUNCE:  deb_r     <= cfg_wdata;
        REG_HEARTBEAT: hb_per_r  <= cfg_wdata;
        REG_REPORT:    rep_per_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // word latch
  always_ff @(posedge clk) begin
    if (cmd.op == OP_LATCH) begin
      mode_r <= in_mode;
      rx_r   <= in_rx_char;
      din_r  <= in_di_sample;
      an1_r  <= in_analog_one;
      an2_r  <= in_analog_two;
    end
  end

  // line memory
  always_ff @(posedge clk) begin
    if (cmd.op == OP_BYTE && rx_r != CH_NL && rx_r != CH_CR &&
        line_len_r < LW'(LINE_DEPTH))
      mem[line_len_r[AW-1:0]] <= rx_r;
    if (cmd.op == OP_SCAN_RD) rdata_r <= mem[cnt_r[AW-1:0]];
  end

  // scan, command and tick state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_len_r  <= '0;
      do_bits_r   <= '0;
      dac1_r      <= '0;
      dac2_r      <= '0;
      pb5_r       <= 1'b0;
      raw_r       <= '0;
      stable_r    <= '0;
      now_r       <= '0;
      hb_stamp_r  <= '0;
      rep_stamp_r <= '0;
      ai_pend_r   <= 1'b0;
      cnt_r       <= '0;
      for (int i = 0; i < INPUT_COUNT; i++) stamp_r[i] <= '0;
    end else begin
      case (cmd.op)
        OP_BYTE: begin
          cnt_r <= '0;
          if (rx_r != CH_NL && rx_r != CH_CR) begin
            if (line_len_r < LW'(LINE_DEPTH)) line_len_r <= line_len_r + LW'(1);
            else line_len_r <= '0;
          end
        end
        OP_SCAN_EX: cnt_r <= CW'(cnt_inc);
        OP_EXEC: begin
          cnt_r      <= '0;
          line_len_r <= '0;
          if (!is_pong && !is_di && !is_dos) begin
            if (is_do) begin
              if (do_ok)
                for (int j = 0; j < OUTPUT_COUNT; j++)
                  if (idx8 == 8'(j + 1)) do_bits_r[j] <= n2[7:0] != 8'd0;
            end else if (is_ao) begin
              if (idx8 == 8'd1) dac1_r <= ao_val;
              else if (idx8 == 8'd2) dac2_r <= ao_val;
            end else if (is_pb5) pb5_r <= idx8 != 8'd0;
          end
        end
        OP_REP_DI, OP_REP_DO: cnt_r <= CW'(cnt_inc);
        OP_TICK: begin
          now_r     <= now_r + TIME_W'(1);
          cnt_r     <= '0;
          ai_pend_r <= 1'b0;
        end
        OP_DEB: begin
          cnt_r <= CW'(cnt_inc);
          if (differ) begin
            stamp_r[ci] <= now_r;
            raw_r[ci]   <= rd;
          end
          if (deb_fire) stable_r[ci] <= rd;
        end
        OP_HB: if (hb_fire) hb_stamp_r <= now_r;
        OP_AI_ONE: if (ai_fire) begin
          rep_stamp_r <= now_r;
          ai_pend_r   <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  // parser registers
  always_ff @(posedge clk) begin
    if (cmd.op == OP_BYTE) begin
      m_ping_r   <= 1'b1;
      m_di_r     <= 1'b1;
      m_dos_r    <= 1'b1;
      m_do_r     <= 1'b1;
      m_ao_r     <= 1'b1;
      m_pb5_r    <= 1'b1;
      comma_r    <= 1'b0;
      scan_len_r <= '0;
      num1_r     <= '{st: NP_WAIT, neg: 1'b0, acc: '0};
      num2_r     <= '{st: NP_WAIT, neg: 1'b0, acc: '0};
    end else if (cmd.op == OP_SCAN_EX && b != 8'd0) begin
      scan_len_r <= LW'(cnt_inc);
      m_ping_r <= m_ping_r && (cnt_x >= CXW'(LEN_PING) ||
                               b == str_at(STR_PING, cnt_r[2:0], LEN_PING));
      m_di_r   <= m_di_r && (cnt_x >= CXW'(LEN_STATE) ||
                             b == str_at(STR_DI, cnt_r[2:0], LEN_STATE));
      m_dos_r  <= m_dos_r && (cnt_x >= CXW'(LEN_STATE) ||
                              b == str_at(STR_DOS, cnt_r[2:0], LEN_STATE));
      m_do_r   <= m_do_r && (cnt_x >= CXW'(LEN_PFX) ||
                             b == str_at(STR_DO, cnt_r[2:0], LEN_PFX));
      m_ao_r   <= m_ao_r && (cnt_x >= CXW'(LEN_PFX) ||
                             b == str_at(STR_AO, cnt_r[2:0], LEN_PFX));
      m_pb5_r  <= m_pb5_r && (cnt_x >= CXW'(LEN_PB5) ||
                              b == str_at(STR_PB5, cnt_r[2:0], LEN_PB5));
      num1_r   <= num_step(num1_r, start1, b);
      if (comma_hit) begin
        comma_r   <= 1'b1;
        num2_r.st <= NP_WS;
      end else num2_r <= num_step(num2_r, 1'b0, b);
    end
  end

  // hold and output registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (gen_v) hold_v_r <= 1'b1;
      else if (cmd.op == OP_FLUSH) hold_v_r <= 1'b0;
      if (load_out) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (gen_v) hold_r <= gen;
    if (load_out) begin
      out_res       <= hold_r;
      out_last      <= cmd.op == OP_FLUSH;
      out_do_levels <= do_bits_r;
      out_dac_one   <= dac1_r;
      out_dac_two   <= dac2_r;
      out_pb5       <= pb5_r;
    end
  end

  assign out_valid = out_valid_r;

endmodule

### rtl/io_command_and_debounce_controller_top.sv
// Steps: a plain byte is latched, then stored; on a newline the non-empty stored line is
//   scanned byte by byte (read, then examine), executed, reported for DI_STATE/DO_STATE,
//   flushed; a tick is latched, advances the timer, debounces each input, checks heartbeat
//   and both analog reports, flushes; result steps stall while an output word is unaccepted.
// Throughput: one word at a time. Reset (synchronous, rst_n low): all board state, timers,
//   stamps cleared, registers back to 25/5000/100 ms; line memory not cleared, needs no sweep.
module io_command_and_debounce_controller_top import iocdc_pkg::*; #(
  parameter int unsigned INPUT_COUNT  = IOCDC_INPUT_COUNT,
  parameter int unsigned OUTPUT_COUNT = IOCDC_OUTPUT_COUNT,
  parameter int unsigned LINE_DEPTH   = IOCDC_LINE_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  iocdc_in_if.sink             in_ch,
  iocdc_out_if.source          out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  // Control and data are split: the sequencer issues one operation per cycle unless it
  // waits for a free output register; the datapath reports back through a status word.
  dp_cmd_t  cmd;
  dp_stat_t stat;
  res_t     res;

  iocdc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Results pass through a one-word hold so that the final word of each input
  // can be marked last before it is shown; the output register decouples the sink.
  iocdc_dp #(
    .INPUT_COUNT  (INPUT_COUNT),
    .OUTPUT_COUNT (OUTPUT_COUNT),
    .LINE_DEPTH   (LINE_DEPTH)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .stat          (stat),
    .in_mode       (in_ch.mode),
    .in_rx_char    (in_ch.rx_char),
    .in_di_sample  (in_ch.di_sample),
    .in_analog_one (in_ch.analog_one),
    .in_analog_two (in_ch.analog_two),
    .cfg_we        (cfg_we),
    .cfg_idx       (cfg_idx),
    .cfg_wdata     (cfg_wdata),
    .out_ready     (out_ch.ready),
    .out_valid     (out_ch.valid),
    .out_res       (res),
    .out_last      (out_ch.last),
    .out_do_levels (out_ch.do_levels),
    .out_dac_one   (out_ch.dac_one),
    .out_dac_two   (out_ch.dac_two),
    .out_pb5       (out_ch.pb5_level)
  );

  assign out_ch.kind    = res.kind;
  assign out_ch.channel = res.channel;
  assign out_ch.value   = res.value;

endmodule

### rtl/iocdc_chk.sv
// Port-level checker for the I/O command controller, bound to the top level.
// Depends on io_command_and_debounce_controller_top_defines.svh.
`include "io_command_and_debounce_controller_top_defines.svh"

module iocdc_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_last,
  input logic [2:0]  out_kind,
  input logic [11:0] out_value
);

  `IOCDC_ASSERT(a_out_hold, (out_valid && !out_ready) |=> out_valid, "output word dropped")
  `IOCDC_ASSERT(a_out_stable, (out_valid && !out_ready) |=> ($stable(out_kind) && $stable(out_value)), "stalled word changed")
  `IOCDC_ASSERT_RST(a_rst_empty, !rst_n |=> !out_valid, "output valid after reset")
  `IOCDC_ASSERT(a_busy_mid, (out_valid && !out_last) |-> !in_ready, "input taken mid result run")
  `IOCDC_ASSERT(a_busy_after, (in_valid && in_ready) |=> !in_ready, "ready right after accept")

endmodule

bind io_command_and_debounce_controller_top iocdc_chk u_iocdc_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_last  (out_ch.last),
  .out_kind  (out_ch.kind),
  .out_value (out_ch.value)
);
